/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

/* design/rte_pkg.sv */
`default_nettype none
package rte_pkg;
    localparam int RingDepth = 8192;
    localparam int RingAw = $clog2(RingDepth);
    localparam int TargetCount = 3;
    localparam int TgtW = (TargetCount > 1) ? $clog2(TargetCount) : 1;
    localparam int PhaseBits = 20;
    localparam int InvTwoPi = 10430;

    typedef enum logic [2:0] {
        REG_ACTIVE = 3'd0,
        REG_DELAYS = 3'd1,
        REG_GAINS  = 3'd2,
        REG_DSTEPS = 3'd3,
        REG_VSTEPS = 3'd4,
        REG_DEPTHS = 3'd5,
        REG_NOISE  = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic         go;
        logic [TgtW:0] count;
    } cell_ctl_t;

    function automatic logic signed [15:0] quarter(input logic [6:0] r);
        logic signed [15:0] v;
        begin
            case (r)
                7'd0: v = 16'sd0;      7'd1: v = 16'sd804;    7'd2: v = 16'sd1608;
                7'd3: v = 16'sd2410;   7'd4: v = 16'sd3212;   7'd5: v = 16'sd4011;
                7'd6: v = 16'sd4808;   7'd7: v = 16'sd5602;   7'd8: v = 16'sd6393;
                7'd9: v = 16'sd7179;   7'd10: v = 16'sd7962;  7'd11: v = 16'sd8739;
                7'd12: v = 16'sd9512;  7'd13: v = 16'sd10278; 7'd14: v = 16'sd11039;
                7'd15: v = 16'sd11793; 7'd16: v = 16'sd12539; 7'd17: v = 16'sd13279;
                7'd18: v = 16'sd14010; 7'd19: v = 16'sd14732; 7'd20: v = 16'sd15446;
                7'd21: v = 16'sd16151; 7'd22: v = 16'sd16846; 7'd23: v = 16'sd17530;
                7'd24: v = 16'sd18204; 7'd25: v = 16'sd18868; 7'd26: v = 16'sd19519;
                7'd27: v = 16'sd20159; 7'd28: v = 16'sd20787; 7'd29: v = 16'sd21403;
                7'd30: v = 16'sd22005; 7'd31: v = 16'sd22594; 7'd32: v = 16'sd23170;
                7'd33: v = 16'sd23731; 7'd34: v = 16'sd24279; 7'd35: v = 16'sd24811;
                7'd36: v = 16'sd25329; 7'd37: v = 16'sd25832; 7'd38: v = 16'sd26319;
                7'd39: v = 16'sd26790; 7'd40: v = 16'sd27245; 7'd41: v = 16'sd27683;
                7'd42: v = 16'sd28105; 7'd43: v = 16'sd28510; 7'd44: v = 16'sd28898;
                7'd45: v = 16'sd29268; 7'd46: v = 16'sd29621; 7'd47: v = 16'sd29956;
                7'd48: v = 16'sd30273; 7'd49: v = 16'sd30571; 7'd50: v = 16'sd30852;
                7'd51: v = 16'sd31113; 7'd52: v = 16'sd31356; 7'd53: v = 16'sd31580;
                7'd54: v = 16'sd31785; 7'd55: v = 16'sd31971; 7'd56: v = 16'sd32137;
                7'd57: v = 16'sd32285; 7'd58: v = 16'sd32412; 7'd59: v = 16'sd32521;
                7'd60: v = 16'sd32609; 7'd61: v = 16'sd32678; 7'd62: v = 16'sd32728;
                7'd63: v = 16'sd32757; 7'd64: v = 16'sd32767;
                default: v = 16'sd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [15:0] sine8(input logic [7:0] a);
        logic [6:0] r;
        logic signed [15:0] v;
        begin
            r = {1'b0, a[5:0]};
            v = a[6] ? quarter(7'd64 - r) : quarter(r);
            return a[7] ? -v : v;
        end
    endfunction
endpackage
`default_nettype wire

/* design/rte_cell.sv */
`default_nettype none
// One target cell: owns its phases, computes its echo over a short pipe and
// adds it to the running sum handed from the previous cell.
module rte_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 active,
    input  wire logic signed [15:0]   echo_i,
    input  wire logic signed [15:0]   echo_q,
    input  wire logic [19:0]          gain,
    input  wire logic [19:0]          dstep,
    input  wire logic [19:0]          vstep,
    input  wire logic [11:0]          depth,
    input  wire logic signed [63:0]   sum_in_i,
    input  wire logic signed [63:0]   sum_in_q,
    output logic signed [63:0]        sum_out_i,
    output logic signed [63:0]        sum_out_q
);
    localparam int PB = rte_pkg::PhaseBits;

    logic [PB-1:0] dph_reg, vph_reg;
    logic signed [28:0] prod1_reg;
    logic [PB-1:0] dph1_reg;
    logic [PB-1:0] off_reg;
    logic signed [15:0] c_reg, s_reg;
    logic signed [15:0] ei1_reg, eq1_reg, ei2_reg, eq2_reg, ei3_reg, eq3_reg;
    logic signed [32:0] re_reg, im_reg;
    logic act1_reg, act2_reg, act3_reg, act4_reg;
    logic [19:0] g1_reg, g2_reg, g3_reg, g4_reg;

    logic signed [28:0] prod_c;
    logic [27:0] mag_c;
    logic [42:0] m_c;
    logic [PB-1:0] ph_c;
    logic [7:0] ang_c;
    logic signed [52:0] gi_c, gq_c;

    always_comb
    begin
        prod_c = $signed({17'd0, depth}) * rte_pkg::sine8(vph_reg[PB-1 -: 8]);
        mag_c  = prod1_reg[28] ? 28'(-prod1_reg) : prod1_reg[27:0];
        m_c    = (43'(mag_c) * 43'(rte_pkg::InvTwoPi)) >> (39 - PB);
        ph_c   = dph1_reg + (prod1_reg[28] ? PB'(-m_c) : PB'(m_c));
        ang_c  = off_reg[PB-1 -: 8];
        gi_c   = re_reg * $signed({1'b0, g4_reg});
        gq_c   = im_reg * $signed({1'b0, g4_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dph_reg <= '0;
            vph_reg <= '0;
            act1_reg <= 1'b0;
            act2_reg <= 1'b0;
            act3_reg <= 1'b0;
            act4_reg <= 1'b0;
        end
        else
        begin
            act1_reg <= start & active;
            act2_reg <= act1_reg;
            act3_reg <= act2_reg;
            act4_reg <= act3_reg;
            if (start && active)
            begin
                dph_reg <= dph_reg + PB'(signed'(dstep));
                vph_reg <= vph_reg + PB'(vstep);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod_c;
        dph1_reg  <= dph_reg;
        ei1_reg <= echo_i;  eq1_reg <= echo_q;  g1_reg <= gain;
        off_reg <= ph_c;
        ei2_reg <= ei1_reg; eq2_reg <= eq1_reg; g2_reg <= g1_reg;
        s_reg <= rte_pkg::sine8(ang_c);
        c_reg <= rte_pkg::sine8(ang_c + 8'd64);
        ei3_reg <= ei2_reg; eq3_reg <= eq2_reg; g3_reg <= g2_reg;
        re_reg <= 33'(ei3_reg * c_reg) - 33'(eq3_reg * s_reg);
        im_reg <= 33'(ei3_reg * s_reg) + 33'(eq3_reg * c_reg);
        g4_reg <= g3_reg;
        sum_out_i <= sum_in_i + (act4_reg ? 64'(gi_c) : 64'sd0);
        sum_out_q <= sum_in_q + (act4_reg ? 64'(gq_c) : 64'sd0);
    end
endmodule
`default_nettype wire

/* design/rte_ring.sv */
`default_nettype none
// Delay ring: one write and per-target reads, one target per cycle.
module rte_ring (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [rte_pkg::RingAw-1:0]    waddr,
    input  wire logic [31:0]                   wdata,
    input  wire logic [rte_pkg::RingAw-1:0]    raddr,
    output logic [31:0]                        rdata
);
    logic [31:0] mem [rte_pkg::RingDepth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* design/radar_target_echo_emulator_top.sv */
`default_nettype none
// Channel   Dir  tdata (low to high)                       tuser
// s_axis    in   in_i, in_q, noise_i, noise_q (64 bits)   -
// m_axis    out  out_i, out_q, clipped (40 bits)           -
// cfg       in   cfg_we, cfg_index, cfg_data               -
// Each request runs on its own, from accept until its result is taken: the
// ring is written on accept, then one ring read per target feeds that target's
// cell, and the cells add their echoes in turn through a five-stage pipe.
// The ring is not reset: entries never written are masked by a fill count.
// s_axis stays stalled while a request is in flight and while its result waits
// on m_axis.
module radar_target_echo_emulator_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // in_i, in_q, noise_i, noise_q
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // out_i, out_q, clipped, pad
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [59:0]  cfg_data
);
    localparam int TC = rte_pkg::TargetCount;
    localparam int AW = rte_pkg::RingAw;
    localparam int LAT = 5;

    logic [1:0]  active_reg;
    logic [38:0] delays_reg;
    logic [59:0] gains_reg, dsteps_reg, vsteps_reg;
    logic [35:0] depths_reg;
    logic [15:0] nscale_reg;

    rte_pkg::state_t state_reg, state_next;
    logic [AW-1:0] wp_reg;
    logic [AW:0]   fill_reg;
    logic [4:0]    cnt_reg;
    logic [63:0]   data_reg;
    logic          ov_reg;
    logic [39:0]   out_reg;
    rte_pkg::cell_ctl_t ctl;

    logic [1:0] cnt_t;
    logic [AW-1:0] raddr;
    logic [12:0] dsel;
    logic [AW-1:0] dcl;
    logic [31:0] rdata;
    logic [TC-1:0] rd_valid_reg;
    logic [TC-1:0] start_v;
    logic [TC-1:0] vmask_reg;
    logic signed [63:0] sum_i [TC+1];
    logic signed [63:0] sum_q [TC+1];
    logic signed [63:0] fi, fq, ri, rq;
    logic ci, cq;
    logic [15:0] oi, oq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0; delays_reg <= '0; gains_reg <= '0; dsteps_reg <= '0;
            vsteps_reg <= '0; depths_reg <= '0; nscale_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rte_pkg::REG_ACTIVE: active_reg <= cfg_data[1:0];
                rte_pkg::REG_DELAYS: delays_reg <= cfg_data[38:0];
                rte_pkg::REG_GAINS:  gains_reg  <= cfg_data;
                rte_pkg::REG_DSTEPS: dsteps_reg <= cfg_data;
                rte_pkg::REG_VSTEPS: vsteps_reg <= cfg_data;
                rte_pkg::REG_DEPTHS: depths_reg <= cfg_data[35:0];
                rte_pkg::REG_NOISE:  nscale_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign ctl.go = (state_reg == rte_pkg::ST_IDLE) && s_axis_tvalid && s_axis_tready;
    assign ctl.count = (rte_pkg::TgtW+1)'((active_reg > 2'(TC)) ? 2'(TC) : active_reg);
    assign s_axis_tready = (state_reg == rte_pkg::ST_IDLE) && !ov_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rte_pkg::ST_IDLE: if (ctl.go) state_next = rte_pkg::ST_RUN;
            rte_pkg::ST_RUN:  if (cnt_reg == 5'(TC + LAT - 1)) state_next = rte_pkg::ST_DONE;
            rte_pkg::ST_DONE: state_next = rte_pkg::ST_IDLE;
            default: state_next = rte_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_t = (cnt_reg < 5'(TC)) ? cnt_reg[1:0] : 2'd0;
        dsel = delays_reg[13*cnt_t +: 13];
        dcl = (32'(dsel) >= rte_pkg::RingDepth) ? AW'(rte_pkg::RingDepth - 1) : AW'(dsel);
        raddr = wp_reg - dcl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rte_pkg::ST_IDLE;
            wp_reg <= '0;
            fill_reg <= '0;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
            rd_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rte_pkg::ST_RUN && cnt_reg < 5'(TC))
                rd_valid_reg <= TC'(1) << cnt_t;
            else
                rd_valid_reg <= '0;
            if (ctl.go)
                cnt_reg <= '0;
            else if (state_reg == rte_pkg::ST_RUN)
                cnt_reg <= cnt_reg + 5'd1;
            if (state_reg == rte_pkg::ST_DONE)
            begin
                wp_reg <= wp_reg + 1'b1;
                if (fill_reg != (AW+1)'(rte_pkg::RingDepth))
                    fill_reg <= fill_reg + 1'b1;
                ov_reg <= 1'b1;
            end
            else if (ov_reg && m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.go)
            data_reg <= s_axis_tdata;
        if (state_reg == rte_pkg::ST_RUN && cnt_reg < 5'(TC))
            vmask_reg[cnt_t] <= ((AW+1)'(dcl) <= fill_reg);
        if (state_reg == rte_pkg::ST_DONE)
            out_reg <= {7'd0, ci | cq, oq, oi};
    end

    rte_ring u_ring (
        .clk(clk), .we(ctl.go), .waddr(wp_reg), .wdata(s_axis_tdata[31:0]),
        .raddr(raddr), .rdata(rdata)
    );

    assign fi = $signed(data_reg[47:32]) * $signed({1'b0, nscale_reg});
    assign fq = $signed(data_reg[63:48]) * $signed({1'b0, nscale_reg});
    assign sum_i[0] = fi <<< 16;
    assign sum_q[0] = fq <<< 16;

    genvar g;
    generate
        for (g = 0; g < TC; g++)
        begin : gen_cell
            assign start_v[g] = rd_valid_reg[g];
            rte_cell u_cell (
                .clk(clk), .rst_n(rst_n), .start(start_v[g]),
                .active((rte_pkg::TgtW+1)'(g) < ctl.count),
                .echo_i(vmask_reg[g] ? $signed(rdata[15:0]) : 16'sd0),
                .echo_q(vmask_reg[g] ? $signed(rdata[31:16]) : 16'sd0),
                .gain(gains_reg[20*g +: 20]), .dstep(dsteps_reg[20*g +: 20]),
                .vstep(vsteps_reg[20*g +: 20]), .depth(depths_reg[12*g +: 12]),
                .sum_in_i(sum_i[g]), .sum_in_q(sum_q[g]),
                .sum_out_i(sum_i[g+1]), .sum_out_q(sum_q[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        ri = (sum_i[TC] + 64'sd67108864) >>> 27;
        rq = (sum_q[TC] + 64'sd67108864) >>> 27;
        ci = (ri > 64'sd32767) || (ri < -64'sd32768);
        cq = (rq > 64'sd32767) || (rq < -64'sd32768);
        oi = (ri > 64'sd32767) ? 16'h7fff : (ri < -64'sd32768) ? 16'h8000 : ri[15:0];
        oq = (rq > 64'sd32767) ? 16'h7fff : (rq < -64'sd32768) ? 16'h8000 : rq[15:0];
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = out_reg;
endmodule
`default_nettype wire

/* design/rte_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module rte_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    `CHK_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CHK_IMPLY(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0)
    `CHK_IMPLY(a_one_side, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `CHK_NEXT(a_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind radar_target_echo_emulator_top rte_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
